FILE: rtl/mrp_pkg.sv
`default_nettype none

package mrp_pkg;

  // Frame constants
  localparam logic [7:0]  MeterCmd     = 8'hAF;
  localparam logic [15:0] CodeCoinIn   = 16'h0000;
  localparam logic [15:0] CodeCoinOut  = 16'h0001;
  localparam logic [15:0] CodeGames    = 16'h0005;
  localparam logic [8:0]  PosMax       = 9'd511;
  localparam logic [8:0]  PosCommand   = 9'd1;
  localparam logic [8:0]  PosLength    = 9'd2;
  localparam logic [8:0]  PayloadStart = 9'd5;
  localparam logic [9:0]  LenBase      = 10'd3;
  // position of the last byte must be at least this for a 7-byte frame
  localparam logic [8:0]  MinLastPos   = 9'd6;
  localparam logic [31:0] BcdScale     = 32'd100;
  localparam logic [31:0] BcdTen       = 32'd10;
  localparam logic [3:0]  NibbleMask   = 4'hF;

  // Meter slots
  localparam int unsigned NumMeters    = 3;
  localparam int unsigned SlotCoinIn   = 0;
  localparam int unsigned SlotCoinOut  = 1;
  localparam int unsigned SlotGames    = 2;

  typedef enum logic [1:0] {
    PH_CODE_LO,
    PH_CODE_HI,
    PH_SIZE,
    PH_VALUE
  } phase_e;

  // One input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       crc_ok;
  } in_t;

  // One result beat
  typedef struct packed {
    logic [31:0] coin_in_meter;
    logic [31:0] coin_out_meter;
    logic [31:0] games_played_meter;
    logic        frame_valid;
  } out_t;

  // Classified entry from front to back
  typedef struct packed {
    logic       payload;  // byte lies inside the meter payload
    logic [7:0] data;     // lagged byte to parse
    logic       last;     // frame ends with this beat
    logic       hdr_ok;   // length, command and CRC checks passed
  } cmd_t;

  // Queue status between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mrp_front.sv
`default_nettype none

module mrp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire mrp_pkg::in_t  in_i,
  output logic               cmd_push_o,
  output mrp_pkg::cmd_t      cmd_o
);

  logic [8:0] pos_q, pos_d;
  logic [7:0] lag0_q, lag0_d, lag1_q, lag1_d;
  logic [1:0] fill_q, fill_d;
  logic [7:0] len_q, len_d;
  logic       cmd_ok_q, cmd_ok_d;

  logic       parse_en;
  logic [8:0] ppos;
  logic       payload;

  // Position of the lagged byte and payload window
  assign parse_en = (fill_q == 2'd2);
  assign ppos     = pos_q - 9'd2;
  assign payload  = parse_en && (ppos >= mrp_pkg::PayloadStart)
                  && ({1'b0, ppos} < (mrp_pkg::LenBase + {2'b00, len_q}));

  // Header capture, lag shift and position count
  always_comb begin
    pos_d    = pos_q;
    lag0_d   = lag0_q;
    lag1_d   = lag1_q;
    fill_d   = fill_q;
    len_d    = len_q;
    cmd_ok_d = cmd_ok_q;
    if (accept_i) begin
      if (parse_en && ppos == mrp_pkg::PosCommand) begin
        cmd_ok_d = (lag0_q == mrp_pkg::MeterCmd);
      end
      if (parse_en && ppos == mrp_pkg::PosLength) begin
        len_d = lag0_q;
      end
      lag0_d = lag1_q;
      lag1_d = in_i.data_byte;
      if (fill_q != 2'd2) begin
        fill_d = fill_q + 2'd1;
      end
      if (pos_q != mrp_pkg::PosMax) begin
        pos_d = pos_q + 9'd1;
      end
      if (in_i.last_byte) begin
        pos_d    = '0;
        lag0_d   = '0;
        lag1_d   = '0;
        fill_d   = '0;
        len_d    = '0;
        cmd_ok_d = 1'b0;
      end
    end
  end

  // Entry towards the back end; a command byte parsed on the last beat
  // cannot matter, as the frame is then too short anyway
  always_comb begin
    cmd_o.payload = payload;
    cmd_o.data    = lag0_q;
    cmd_o.last    = in_i.last_byte;
    cmd_o.hdr_ok  = (pos_q >= mrp_pkg::MinLastPos) && cmd_ok_q && in_i.crc_ok;
    cmd_push_o    = accept_i && (payload || in_i.last_byte);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      lag0_q   <= '0;
      lag1_q   <= '0;
      fill_q   <= '0;
      len_q    <= '0;
      cmd_ok_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      lag0_q   <= lag0_d;
      lag1_q   <= lag1_d;
      fill_q   <= fill_d;
      len_q    <= len_d;
      cmd_ok_q <= cmd_ok_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mrp_cmd_fifo.sv
`default_nettype none

module mrp_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mrp_pkg::cmd_t  data_i,
  input  wire logic           pop_i,
  output mrp_pkg::cmd_t       data_o,
  output mrp_pkg::q_stat_t    stat_o
);

  mrp_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mrp_back.sv
`default_nettype none

module mrp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mrp_pkg::cmd_t    cmd_i,
  input  wire mrp_pkg::q_stat_t cmd_stat_i,
  output logic                  cmd_pop_o,
  input  wire logic             res_pop_i,
  output logic                  res_empty_o,
  output mrp_pkg::out_t         res_o
);

  mrp_pkg::phase_e    phase_q, phase_d;
  logic [15:0]        code_q, code_d;
  logic [7:0]         left_q, left_d;
  logic [31:0]        acc_q, acc_d;
  logic [2:0][31:0]   meters_q, meters_d;
  logic               any_q, any_d;

  logic               commit_en;
  logic [31:0]        commit_val;
  logic [31:0]        acc_next;
  logic               frame_ok;
  mrp_pkg::out_t      res_new;

  // Result queue, two beats
  mrp_pkg::out_t      res_mem_q [2];
  logic               res_wr_q, res_rd_q;
  logic [1:0]         res_cnt_q, res_cnt_d;
  logic               res_push, res_pop;

  // Take an entry unless it ends a frame and the result queue is full
  assign cmd_pop_o = !cmd_stat_i.empty && (!cmd_i.last || res_cnt_q != 2'd2);
  assign res_push  = cmd_pop_o && cmd_i.last;

  // BCD step: acc * 100 + hi * 10 + lo, wrapping
  assign acc_next = acc_q * mrp_pkg::BcdScale
                  + 32'(cmd_i.data[7:4] & mrp_pkg::NibbleMask) * mrp_pkg::BcdTen
                  + 32'(cmd_i.data[3:0] & mrp_pkg::NibbleMask);

  // Triple parser
  always_comb begin
    phase_d    = phase_q;
    code_d     = code_q;
    left_d     = left_q;
    acc_d      = acc_q;
    commit_en  = 1'b0;
    commit_val = '0;
    if (cmd_pop_o && cmd_i.payload) begin
      case (phase_q)
        mrp_pkg::PH_CODE_LO: begin
          code_d  = {8'h00, cmd_i.data};
          phase_d = mrp_pkg::PH_CODE_HI;
        end
        mrp_pkg::PH_CODE_HI: begin
          code_d  = {cmd_i.data, code_q[7:0]};
          phase_d = mrp_pkg::PH_SIZE;
        end
        mrp_pkg::PH_SIZE: begin
          if (cmd_i.data == 8'h00) begin
            commit_en = 1'b1;
            phase_d   = mrp_pkg::PH_CODE_LO;
          end else begin
            left_d  = cmd_i.data;
            acc_d   = '0;
            phase_d = mrp_pkg::PH_VALUE;
          end
        end
        mrp_pkg::PH_VALUE: begin
          acc_d  = acc_next;
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) begin
            commit_en  = 1'b1;
            commit_val = acc_next;
            phase_d    = mrp_pkg::PH_CODE_LO;
          end
        end
        default: begin
          phase_d = mrp_pkg::PH_CODE_LO;
        end
      endcase
    end
  end

  // Meter commit for known codes
  always_comb begin
    meters_d = meters_q;
    any_d    = any_q;
    if (commit_en) begin
      if (code_q == mrp_pkg::CodeCoinIn) begin
        meters_d[mrp_pkg::SlotCoinIn] = commit_val;
        any_d = 1'b1;
      end else if (code_q == mrp_pkg::CodeCoinOut) begin
        meters_d[mrp_pkg::SlotCoinOut] = commit_val;
        any_d = 1'b1;
      end else if (code_q == mrp_pkg::CodeGames) begin
        meters_d[mrp_pkg::SlotGames] = commit_val;
        any_d = 1'b1;
      end
    end
  end

  // Result of the frame, zeroed when a check fails
  always_comb begin
    frame_ok                   = cmd_i.hdr_ok && any_d;
    res_new.coin_in_meter      = frame_ok ? meters_d[mrp_pkg::SlotCoinIn] : '0;
    res_new.coin_out_meter     = frame_ok ? meters_d[mrp_pkg::SlotCoinOut] : '0;
    res_new.games_played_meter = frame_ok ? meters_d[mrp_pkg::SlotGames] : '0;
    res_new.frame_valid        = frame_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mrp_pkg::PH_CODE_LO;
      code_q   <= '0;
      left_q   <= '0;
      acc_q    <= '0;
      meters_q <= '0;
      any_q    <= 1'b0;
    end else if (res_push) begin
      phase_q  <= mrp_pkg::PH_CODE_LO;
      code_q   <= '0;
      left_q   <= '0;
      acc_q    <= '0;
      meters_q <= '0;
      any_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      code_q   <= code_d;
      left_q   <= left_d;
      acc_q    <= acc_d;
      meters_q <= meters_d;
      any_q    <= any_d;
    end
  end

  // Result queue
  assign res_empty_o = (res_cnt_q == 2'd0);
  assign res_pop     = res_pop_i && !res_empty_o;
  assign res_o       = res_mem_q[res_rd_q];

  always_comb begin
    res_cnt_d = res_cnt_q;
    if (res_push && !res_pop) begin
      res_cnt_d = res_cnt_q + 2'd1;
    end else if (res_pop && !res_push) begin
      res_cnt_d = res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= '0;
    end else begin
      res_cnt_q <= res_cnt_d;
      if (res_push) begin
        res_wr_q <= !res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= !res_rd_q;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/meter_response_parser_top.sv
// Throughput: one byte per cycle while full is low; the back end retires one entry each
//   cycle unless that entry ends a frame and the result queue is full.
// A frame's last byte is queued as an entry; retiring it writes the result queue.
// Up to two results are held; full rises only when both queues back up.
// Reset: rst_ni is asynchronous, active low; it clears all frame state and both queues.
`default_nettype none

module meter_response_parser_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire mrp_pkg::in_t  in_data_i,
  output logic               empty,
  input  wire logic          pop,
  output mrp_pkg::out_t      res_data_o
);

  logic             accept;
  logic             cmd_push;
  logic             cmd_pop;
  mrp_pkg::cmd_t    cmd_in;
  mrp_pkg::cmd_t    cmd_out;
  mrp_pkg::q_stat_t cmd_stat;

  assign full   = cmd_stat.full;
  assign accept = push && !full;

  mrp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  mrp_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .pop_i  (cmd_pop),
    .data_o (cmd_out),
    .stat_o (cmd_stat)
  );

  mrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_stat_i  (cmd_stat),
    .cmd_pop_o   (cmd_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res_data_o)
  );

  // Entry queue status is consistent
  a_cmd_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_stat.full && cmd_stat.empty))
    else $error("entry queue both full and empty");

  // A result only appears after the back end retired a frame end
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && $past(empty)) |-> $past(cmd_pop && cmd_out.last))
    else $error("result appeared without a frame end");

  // Failed frame reads all meters as zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_data_o.frame_valid) |->
      (res_data_o.coin_in_meter == '0 && res_data_o.coin_out_meter == '0
       && res_data_o.games_played_meter == '0))
    else $error("invalid frame with nonzero meters");

  // Back end never retires from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_stat.empty)
    else $error("entry popped from empty queue");

endmodule

`default_nettype wire
